@@ hw/rtl/tsi_pkg.sv @@
package tsi_pkg;

    // Element index width, fixed by the index fields.
    localparam int IDX_W      = 32;
    // Number of dimension size registers.
    localparam int NUM_DIMS   = 4;
    localparam int RANK_W     = 3;
    localparam int AXIS_W     = 2;
    localparam int CFG_IDX_W  = 3;

    // Register map of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANK   = 3'd0,
        REG_DIM0   = 3'd1,
        REG_DIM1   = 3'd2,
        REG_DIM2   = 3'd3,
        REG_DIM3   = 3'd4,
        REG_AXIS_A = 3'd5,
        REG_AXIS_B = 3'd6
    } t_cfg_reg;

    localparam logic [RANK_W-1:0] RANK_RESET   = 3'd2;
    localparam logic [AXIS_W-1:0] AXIS_A_RESET = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_B_RESET = 2'd1;

endpackage

@@ hw/rtl/tsi_divider.sv @@
module tsi_divider #(
    parameter int DIM_BITS = 16,
    parameter int SIDE_W   = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [tsi_pkg::IDX_W-1:0]  i_dividend,
    input  logic [DIM_BITS-1:0]        i_divisor,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_valid,
    output logic [tsi_pkg::IDX_W-1:0]  o_quotient,
    output logic [DIM_BITS-1:0]        o_remainder,
    output logic [SIDE_W-1:0]          o_side
);
    import tsi_pkg::*;

    // One quotient bit per stage, restoring division, most significant bit first.
    logic                 r_vld  [IDX_W];
    logic [DIM_BITS-1:0]  r_rem  [IDX_W];
    logic [IDX_W-1:0]     r_q    [IDX_W];
    logic [SIDE_W-1:0]    r_side [IDX_W];

    genvar s;
    generate
        for (s = 0; s < IDX_W; s++) begin : g_stage
            logic                vld_in;
            logic [DIM_BITS-1:0] rem_in;
            logic [IDX_W-1:0]    q_in;
            logic [SIDE_W-1:0]   side_in;
            logic [DIM_BITS:0]   trial;
            logic [DIM_BITS:0]   diff;
            logic                take;
            logic [DIM_BITS-1:0] n_rem;
            logic [IDX_W-1:0]    n_q;

            if (s == 0) begin : g_first
                assign vld_in  = i_valid;
                assign rem_in  = '0;
                assign q_in    = i_dividend;
                assign side_in = i_side;
            end else begin : g_next
                assign vld_in  = r_vld[s-1];
                assign rem_in  = r_rem[s-1];
                assign q_in    = r_q[s-1];
                assign side_in = r_side[s-1];
            end

            always_comb begin
                trial = {rem_in, q_in[IDX_W-1]};
                diff  = trial - {1'b0, i_divisor};
                take  = (trial >= {1'b0, i_divisor});
                n_rem = take ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
                n_q   = {q_in[IDX_W-2:0], take};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[s]  <= n_rem;
                r_q[s]    <= n_q;
                r_side[s] <= side_in;
            end
        end
    endgenerate

    assign o_valid     = r_vld[IDX_W-1];
    assign o_quotient  = r_q[IDX_W-1];
    assign o_remainder = r_rem[IDX_W-1];
    assign o_side      = r_side[IDX_W-1];

endmodule

@@ hw/rtl/tsi_recombine.sv @@
module tsi_recombine #(
    parameter int DIM_BITS = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    input  logic [tsi_pkg::NUM_DIMS-1:0][DIM_BITS-1:0]    i_coord,
    input  logic [tsi_pkg::NUM_DIMS-1:0][DIM_BITS-1:0]    i_shape,
    output logic                                          o_valid,
    output logic [tsi_pkg::IDX_W-1:0]                     o_index
);
    import tsi_pkg::*;

    localparam int NUM_STG = NUM_DIMS - 1;
    localparam int PROD_W  = IDX_W + DIM_BITS;

    // Horner form: each stage takes acc * shape + coord, modulo 2^32.
    logic                                  r_vld   [NUM_STG];
    logic [IDX_W-1:0]                      r_acc   [NUM_STG];
    logic [NUM_DIMS-1:0][DIM_BITS-1:0]     r_coord [NUM_STG-1];

    genvar j;
    generate
        for (j = 0; j < NUM_STG; j++) begin : g_stage
            logic                              vld_in;
            logic [IDX_W-1:0]                  acc_in;
            logic [NUM_DIMS-1:0][DIM_BITS-1:0] coord_in;
            logic [PROD_W-1:0]                 prod;
            logic [IDX_W-1:0]                  n_acc;

            if (j == 0) begin : g_first
                assign vld_in   = i_valid;
                assign acc_in   = IDX_W'(i_coord[0]);
                assign coord_in = i_coord;
            end else begin : g_next
                assign vld_in   = r_vld[j-1];
                assign acc_in   = r_acc[j-1];
                assign coord_in = r_coord[j-1];
            end

            always_comb begin
                prod  = PROD_W'(acc_in) * PROD_W'(i_shape[j+1]);
                n_acc = prod[IDX_W-1:0] + IDX_W'(coord_in[j+1]);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[j] <= 1'b0;
                end else begin
                    r_vld[j] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_acc[j] <= n_acc;
            end

            if (j < NUM_STG - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    r_coord[j] <= coord_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[NUM_STG-1];
    assign o_index = r_acc[NUM_STG-1];

endmodule

@@ hw/rtl/tensor_axis_swap_index.sv @@
// Transpose address generator. A row-major element index of a tensor of up
// to four dimensions goes in; the row-major index of the same element after
// two axes are swapped comes out.
// Request channel: a request is taken at every rising edge with i_start high
// while o_busy is low. o_busy is held low, so a new request may enter in
// every cycle and the block sustains one index per clock.
// Result channel: o_valid strobes for one cycle with o_swapped_index. The
// result of a request passes through four pipelined 32-stage dividers (one
// quotient bit per stage, one divider per axis), one stage for the coordinate
// swap, and three multiply-add stages that rebuild the index. Results leave in
// request order. The receiver cannot stall, so the pipeline never holds.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (rank,
// four dimension sizes, axis A, axis B). Write only while no request is in
// flight. A size of zero acts as one, rank is clamped to 1..MAX_RANK, and a
// swap axis at or above the rank disables the swap.
// Reset (synchronous, active low) restores rank 2, all sizes 1, axes 0 and 1,
// and drops every request in flight.
module tensor_axis_swap_index #(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [tsi_pkg::IDX_W-1:0]         i_linear_index,
    output logic                              o_valid,
    output logic [tsi_pkg::IDX_W-1:0]         o_swapped_index,
    input  logic                              i_cfg_we,
    input  logic [tsi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DIM_BITS-1:0]               i_cfg_data
);
    import tsi_pkg::*;

    localparam int SIDE_W = NUM_DIMS * DIM_BITS;

    // Configuration registers.
    logic [RANK_W-1:0]    r_rank;
    logic [DIM_BITS-1:0]  r_dim [NUM_DIMS];
    logic [AXIS_W-1:0]    r_axis_a;
    logic [AXIS_W-1:0]    r_axis_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank   <= RANK_RESET;
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_dim[d] <= DIM_BITS'(1);
            end
            r_axis_a <= AXIS_A_RESET;
            r_axis_b <= AXIS_B_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_RANK:   r_rank   <= i_cfg_data[RANK_W-1:0];
                REG_DIM0:   r_dim[0] <= i_cfg_data;
                REG_DIM1:   r_dim[1] <= i_cfg_data;
                REG_DIM2:   r_dim[2] <= i_cfg_data;
                REG_DIM3:   r_dim[3] <= i_cfg_data;
                REG_AXIS_A: r_axis_a <= i_cfg_data[AXIS_W-1:0];
                REG_AXIS_B: r_axis_b <= i_cfg_data[AXIS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Shape decode; every stage reads these decoded values directly. The user
    // must change configuration only while the pipeline is empty; not enforced.
    logic [RANK_W-1:0]                   w_rank;
    logic                                w_do_swap;
    logic [NUM_DIMS-1:0][DIM_BITS-1:0]   w_size;
    logic [NUM_DIMS-1:0][DIM_BITS-1:0]   w_shape;
    logic [AXIS_W-1:0]                   w_src [NUM_DIMS];

    always_comb begin
        w_rank = r_rank;
        if (w_rank == '0) begin
            w_rank = RANK_W'(1);
        end
        if (w_rank > RANK_W'(MAX_RANK)) begin
            w_rank = RANK_W'(MAX_RANK);
        end

        w_do_swap = (RANK_W'(r_axis_a) < w_rank) && (RANK_W'(r_axis_b) < w_rank);

        // Axes outside the rank act as size one and hold coordinate zero, so
        // they pass through both the split and the rebuild unchanged.
        for (int p = 0; p < NUM_DIMS; p++) begin
            if (RANK_W'(p) >= w_rank || r_dim[p] == '0) begin
                w_size[p] = DIM_BITS'(1);
            end else begin
                w_size[p] = r_dim[p];
            end
        end

        // Source axis of each position after the swap.
        for (int p = 0; p < NUM_DIMS; p++) begin
            if (w_do_swap && AXIS_W'(p) == r_axis_a) begin
                w_src[p] = r_axis_b;
            end else if (w_do_swap && AXIS_W'(p) == r_axis_b) begin
                w_src[p] = r_axis_a;
            end else begin
                w_src[p] = AXIS_W'(p);
            end
        end

        for (int p = 0; p < NUM_DIMS; p++) begin
            w_shape[p] = '0;
            for (int q = 0; q < NUM_DIMS; q++) begin
                if (w_src[p] == AXIS_W'(q)) begin
                    w_shape[p] = w_size[q];
                end
            end
        end
    end

    // Every cycle can take a request.
    assign o_busy = 1'b0;

    // Coordinate split: divider k peels off the coordinate of axis
    // NUM_DIMS-1-k. Axis 0 takes the remainder of the last quotient, which
    // wraps indices beyond the tensor.
    logic                              w_vld   [NUM_DIMS+1];
    logic [IDX_W-1:0]                  w_div   [NUM_DIMS];
    logic [NUM_DIMS-1:0][DIM_BITS-1:0] w_coord [NUM_DIMS+1];

    assign w_vld[0]   = i_start & ~o_busy;
    assign w_div[0]   = i_linear_index;
    assign w_coord[0] = '0;

    genvar k;
    generate
        for (k = 0; k < NUM_DIMS; k++) begin : g_split
            localparam int POS = NUM_DIMS - 1 - k;
            logic [DIM_BITS-1:0] rem;
            logic [SIDE_W-1:0]   side_out;

            if (k < NUM_DIMS - 1) begin : g_mid
                tsi_divider #(
                    .DIM_BITS (DIM_BITS),
                    .SIDE_W   (SIDE_W)
                ) u_div (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_valid     (w_vld[k]),
                    .i_dividend  (w_div[k]),
                    .i_divisor   (w_size[POS]),
                    .i_side      (w_coord[k]),
                    .o_valid     (w_vld[k+1]),
                    .o_quotient  (w_div[k+1]),
                    .o_remainder (rem),
                    .o_side      (side_out)
                );
            end else begin : g_last
                // The final quotient is beyond the tensor and is dropped.
                tsi_divider #(
                    .DIM_BITS (DIM_BITS),
                    .SIDE_W   (SIDE_W)
                ) u_div (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_valid     (w_vld[k]),
                    .i_dividend  (w_div[k]),
                    .i_divisor   (w_size[POS]),
                    .i_side      (w_coord[k]),
                    .o_valid     (w_vld[k+1]),
                    .o_quotient  (),
                    .o_remainder (rem),
                    .o_side      (side_out)
                );
            end

            always_comb begin
                w_coord[k+1]      = side_out;
                w_coord[k+1][POS] = rem;
            end
        end
    endgenerate

    // Swap stage: each position picks its coordinate from its source axis.
    logic                              r_sw_vld;
    logic [NUM_DIMS-1:0][DIM_BITS-1:0] r_sw_coord;
    logic [NUM_DIMS-1:0][DIM_BITS-1:0] n_sw_coord;

    always_comb begin
        for (int p = 0; p < NUM_DIMS; p++) begin
            n_sw_coord[p] = '0;
            for (int q = 0; q < NUM_DIMS; q++) begin
                if (w_src[p] == AXIS_W'(q)) begin
                    n_sw_coord[p] = w_coord[NUM_DIMS][q];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_vld <= 1'b0;
        end else begin
            r_sw_vld <= w_vld[NUM_DIMS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sw_coord <= n_sw_coord;
    end

    // Rebuild the row-major index against the swapped shape.
    tsi_recombine #(
        .DIM_BITS (DIM_BITS)
    ) u_recombine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_sw_vld),
        .i_coord (r_sw_coord),
        .i_shape (w_shape),
        .o_valid (o_valid),
        .o_index (o_swapped_index)
    );

endmodule
